/* src/zsce_pkg.sv */
// zsce_pkg: shared types and constants of the zoomed sprite chunk expander
// used by zsce_decode, zoomed_sprite_chunk_expander and the testbench
`timescale 1ns / 1ps

package zsce_pkg;

    // request action codes
    localparam logic        ACT_WRITE  = 1'b0;
    localparam logic        ACT_EXPAND = 1'b1;

    // raw y that marks the end of the sprite list
    localparam logic [8:0]  END_OF_LIST_Y = 9'h180;
    // coordinates above this are negative
    localparam logic [10:0] SIGN_LIMIT    = 11'h140;
    localparam logic [9:0]  COORD_WRAP    = 10'h200;
    // y bias: 3 plus 128 before the zoom y is taken off
    localparam logic [10:0] Y_BIAS        = 11'd131;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_EXPAND = 3'b010,
        ST_END    = 3'b100
    } state_t;

    // decoded sprite descriptor for one row
    typedef struct packed {
        logic       list_end;
        logic [7:0] tile;
        logic [7:0] colour;
        logic       flip_x;
        logic       flip_y;
        logic       pri;
        logic [7:0] zoom_x;   // 1..128
        logic [9:0] pos_x;    // signed, two's complement
        logic [9:0] pos_y;    // row y, signed, two's complement
        logic [3:0] size_y;
        logic [3:0] row_sel;  // chunk row after vertical flip
    } desc_t;

endpackage

/* src/zoomed_sprite_chunk_expander.sv */
// zoomed_sprite_chunk_expander: top level with the chunk map memory and the
// row sequencer; uses zsce_pkg and zsce_decode
`timescale 1ns / 1ps

// A write request (action 0) stores one 16-bit chunk map word and gives no
// result. An expand request (action 1) decodes a sprite descriptor and gives
// eight chunk results of the chosen row, k = 0..7 with last on the eighth;
// it keeps in_stall high until the last chunk is loaded into the output
// register. The eight reads of the single-port chunk map go one per cycle
// while the output register is not held full by out_stall, the first one
// issued in the cycle the request is taken. A descriptor with raw y 0x180
// gives a single end-of-list result instead and keeps in_stall high until
// that result is loaded into the output register. A result that waits at
// the output does not block write requests. While a full output register
// is stalled the sequencer holds after the read in flight. MAP_WORDS must
// be a power of two; map addresses wrap modulo MAP_WORDS. A map word that
// was never written reads as an unknown value. The map has no reset and no
// clearing pass.

module zoomed_sprite_chunk_expander
#(
    parameter int MAP_WORDS = 32768
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [14:0]        map_address,
    input  logic [15:0]        map_data,
    input  logic [15:0]        desc_word0,
    input  logic [15:0]        desc_word1,
    input  logic [15:0]        desc_word2,
    input  logic [15:0]        desc_word3,
    input  logic [3:0]         row_index,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [14:0]        tile_code,
    output logic [7:0]         colour,
    output logic               flip_x,
    output logic               flip_y,
    output logic signed [9:0]  pos_x,
    output logic signed [9:0]  pos_y,
    output logic [4:0]         size_x,
    output logic [3:0]         size_y,
    output logic               priority_res,
    output logic               chunk_valid,
    output logic               list_end,
    output logic               last
);

    localparam int AW = $clog2(MAP_WORDS);

    // chunk map, single port, registered read
    logic [15:0]       map_mem [MAP_WORDS];
    logic [15:0]       rd_data_reg;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_addr;
    logic [14:0]       rd_word_addr;

    zsce_pkg::desc_t   desc;
    zsce_pkg::state_t  state_reg, state_next;

    // per-request registers
    logic [7:0]        tile_reg;
    logic [7:0]        colour_reg;
    logic              fx_reg, fy_reg, pri_reg;
    logic [7:0]        zx_reg;
    logic [9:0]        x_reg;
    logic [9:0]        y_reg;
    logic [3:0]        sy_reg;
    logic [3:0]        row_reg;

    // sequencer
    logic [3:0]        iss_cnt_reg, iss_cnt_next;   // reads issued, 0..8
    logic [2:0]        k_out_reg, k_out_next;       // chunk loaded next
    logic              pend_reg, pend_next;         // read data waits in rd_data_reg
    logic [9:0]        acc_reg, acc_next;           // k times zoom x
    logic [10:0]       acc_sum;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic              out_free;
    logic              accept;
    logic              start_expand;
    logic              load_chunk;
    logic              load_end;
    logic [2:0]        iss_k;
    logic [2:0]        px;

    zsce_decode u_decode
    (
        .desc_word0 (desc_word0),
        .desc_word1 (desc_word1),
        .desc_word2 (desc_word2),
        .desc_word3 (desc_word3),
        .row_index  (row_index),
        .desc       (desc)
    );

    // the block takes a request only between rows
    assign in_stall  = (state_reg != zsce_pkg::ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    assign start_expand = accept && (action == zsce_pkg::ACT_EXPAND) && !desc.list_end;
    assign load_chunk   = (state_reg == zsce_pkg::ST_EXPAND) && pend_reg && out_free;
    assign load_end     = (state_reg == zsce_pkg::ST_END) && out_free;

    // chunk k lands in the output: x offset and width from the running k * zx
    assign acc_sum = {1'b0, acc_reg} + {3'b000, zx_reg};

    // read issue: first read straight from the request, the rest from registers
    always_comb
    begin
        iss_k        = iss_cnt_reg[2:0];
        mem_re       = 1'b0;
        rd_word_addr = {tile_reg, row_reg, fx_reg ? ~iss_k : iss_k};
        px           = desc.flip_x ? 3'b111 : 3'b000;
        if (start_expand)
        begin
            mem_re       = 1'b1;
            rd_word_addr = {desc.tile, desc.row_sel, px};
        end
        else if ((state_reg == zsce_pkg::ST_EXPAND) && !iss_cnt_reg[3]
                 && (!pend_reg || out_free))
        begin
            mem_re = 1'b1;
        end
    end

    assign mem_we   = accept && (action == zsce_pkg::ACT_WRITE);
    assign mem_addr = mem_we ? AW'(map_address) : AW'(rd_word_addr);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_addr] <= map_data;
        end
        else if (mem_re)
        begin
            rd_data_reg <= map_mem[mem_addr];
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        iss_cnt_next   = iss_cnt_reg;
        k_out_next     = k_out_reg;
        acc_next       = acc_reg;
        pend_next      = mem_re ? 1'b1 : (load_chunk ? 1'b0 : pend_reg);
        out_valid_next = (load_chunk || load_end) ? 1'b1
                       : (out_stall ? out_valid_reg : 1'b0);
        if (mem_re)
        begin
            iss_cnt_next = iss_cnt_reg + 4'd1;
        end
        unique case (state_reg)
            zsce_pkg::ST_IDLE:
            begin
                if (accept && (action == zsce_pkg::ACT_EXPAND))
                begin
                    if (desc.list_end)
                    begin
                        state_next = zsce_pkg::ST_END;
                    end
                    else
                    begin
                        state_next   = zsce_pkg::ST_EXPAND;
                        iss_cnt_next = 4'd1;
                        k_out_next   = 3'd0;
                        acc_next     = 10'd0;
                    end
                end
            end
            zsce_pkg::ST_EXPAND:
            begin
                if (load_chunk)
                begin
                    k_out_next = k_out_reg + 3'd1;
                    acc_next   = acc_sum[9:0];
                    if (k_out_reg == 3'd7)
                    begin
                        state_next = zsce_pkg::ST_IDLE;
                    end
                end
            end
            zsce_pkg::ST_END:
            begin
                if (load_end)
                begin
                    state_next = zsce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = zsce_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= zsce_pkg::ST_IDLE;
            iss_cnt_reg   <= 4'd0;
            k_out_reg     <= 3'd0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_cnt_reg   <= iss_cnt_next;
            k_out_reg     <= k_out_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // descriptor fields held for the row
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start_expand)
        begin
            tile_reg   <= desc.tile;
            colour_reg <= desc.colour;
            fx_reg     <= desc.flip_x;
            fy_reg     <= desc.flip_y;
            pri_reg    <= desc.pri;
            zx_reg     <= desc.zoom_x;
            x_reg      <= desc.pos_x;
            y_reg      <= desc.pos_y;
            sy_reg     <= desc.size_y;
            row_reg    <= desc.row_sel;
        end
    end

    // output register: a chunk result, or the end-of-list result with all chunk fields zero
    always_ff @(posedge clk)
    begin
        if (load_chunk)
        begin
            tile_code    <= rd_data_reg[14:0];
            colour       <= colour_reg;
            flip_x       <= fx_reg;
            flip_y       <= fy_reg;
            pos_x        <= x_reg + {3'b000, acc_reg[9:3]};
            pos_y        <= y_reg;
            size_x       <= 5'(acc_sum[10:3] - {1'b0, acc_reg[9:3]});
            size_y       <= sy_reg;
            priority_res <= pri_reg;
            chunk_valid  <= !rd_data_reg[15];
            list_end     <= 1'b0;
            last         <= (k_out_reg == 3'd7);
        end
        else if (load_end)
        begin
            tile_code    <= 15'd0;
            colour       <= 8'd0;
            flip_x       <= 1'b0;
            flip_y       <= 1'b0;
            pos_x        <= 10'sd0;
            pos_y        <= 10'sd0;
            size_x       <= 5'd0;
            size_y       <= 4'd0;
            priority_res <= 1'b0;
            chunk_valid  <= 1'b0;
            list_end     <= 1'b1;
            last         <= 1'b1;
        end
    end

endmodule

/* src/zsce_decode.sv */
// zsce_decode: splits a four-word sprite descriptor into its fields and
// works out the row position and height; uses zsce_pkg
`timescale 1ns / 1ps

module zsce_decode
(
    input  logic [15:0]         desc_word0,
    input  logic [15:0]         desc_word1,
    input  logic [15:0]         desc_word2,
    input  logic [15:0]         desc_word3,
    input  logic [3:0]          row_index,
    output zsce_pkg::desc_t     desc
);

    logic [8:0]  raw_y;
    logic [8:0]  raw_x;
    logic [7:0]  zoom_y;
    logic [10:0] y_biased;
    logic [9:0]  y_signed;
    logic [9:0]  x_signed;
    logic [10:0] row_off;     // row times zoom y, up to 1920
    logic [11:0] row_off_nxt; // next row offset, up to 2048

    always_comb
    begin
        raw_y    = desc_word0[8:0];
        raw_x    = desc_word2[8:0];
        zoom_y   = {1'b0, desc_word0[15:9]} + 8'd1;

        y_biased = {2'b00, raw_y} + zsce_pkg::Y_BIAS - {3'b000, zoom_y};
        y_signed = (y_biased > zsce_pkg::SIGN_LIMIT)
                 ? (y_biased[9:0] - zsce_pkg::COORD_WRAP) : y_biased[9:0];
        x_signed = ({2'b00, raw_x} > zsce_pkg::SIGN_LIMIT)
                 ? ({1'b0, raw_x} - zsce_pkg::COORD_WRAP) : {1'b0, raw_x};

        row_off     = {7'b0000000, row_index} * {3'b000, zoom_y};
        row_off_nxt = {1'b0, row_off} + {4'b0000, zoom_y};

        desc.list_end = (raw_y == zsce_pkg::END_OF_LIST_Y);
        desc.tile     = desc_word3[7:0];
        desc.colour   = desc_word3[15:8];
        desc.flip_x   = desc_word2[14];
        desc.flip_y   = desc_word1[15];
        desc.pri      = desc_word2[15];
        desc.zoom_x   = {1'b0, desc_word1[6:0]} + 8'd1;
        desc.pos_x    = x_signed;
        desc.pos_y    = y_signed + {3'b000, row_off[10:4]};
        desc.size_y   = 4'(row_off_nxt[11:4] - {1'b0, row_off[10:4]});
        desc.row_sel  = desc_word1[15] ? ~row_index : row_index;
    end

endmodule

/* src/zsce_checker.sv */
// zsce_props: port-level assertions for zoomed_sprite_chunk_expander
// and the bind that attaches them; uses no package
`timescale 1ns / 1ps

module zsce_props
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               action,
    input  logic [14:0]        map_address,
    input  logic [15:0]        map_data,
    input  logic [15:0]        desc_word0,
    input  logic [15:0]        desc_word1,
    input  logic [15:0]        desc_word2,
    input  logic [15:0]        desc_word3,
    input  logic [3:0]         row_index,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [14:0]        tile_code,
    input  logic [7:0]         colour,
    input  logic               flip_x,
    input  logic               flip_y,
    input  logic signed [9:0]  pos_x,
    input  logic signed [9:0]  pos_y,
    input  logic [4:0]         size_x,
    input  logic [3:0]         size_y,
    input  logic               priority_res,
    input  logic               chunk_valid,
    input  logic               list_end,
    input  logic               last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(tile_code) && $stable(pos_x)
            && $stable(last) && $stable(list_end))
        else $error("stalled result changed");

    // an end-of-list result is a single, final result
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && list_end |-> last)
        else $error("end-of-list result without last");

    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && list_end |-> (tile_code == 15'd0) && (size_x == 5'd0)
            && (size_y == 4'd0) && (pos_x == 10'sd0) && !chunk_valid)
        else $error("end-of-list result carries chunk fields");

    // zoomed chunk sizes stay within one unzoomed chunk
    a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !list_end |-> (size_x <= 5'd16) && (size_y <= 4'd8))
        else $error("chunk size out of range");

    // an expand request keeps the input stalled in the next cycle
    a_expand_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && action |=> in_stall)
        else $error("expand request did not hold the input");

endmodule

bind zoomed_sprite_chunk_expander zsce_props u_zsce_props (.*);

/* tb/zsce_checker.sv */
// zsce_checker: watches the request and result channels of the chunk expander,
// predicts each chunk from its own copy of the chunk map and compares; uses zsce_pkg
`timescale 1ns / 1ps

module zsce_checker
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               action,
    input  logic [14:0]        map_address,
    input  logic [15:0]        map_data,
    input  logic [15:0]        desc_word0,
    input  logic [15:0]        desc_word1,
    input  logic [15:0]        desc_word2,
    input  logic [15:0]        desc_word3,
    input  logic [3:0]         row_index,

    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [14:0]        tile_code,
    input  logic [7:0]         colour,
    input  logic               flip_x,
    input  logic               flip_y,
    input  logic signed [9:0]  pos_x,
    input  logic signed [9:0]  pos_y,
    input  logic [4:0]         size_x,
    input  logic [3:0]         size_y,
    input  logic               priority_res,
    input  logic               chunk_valid,
    input  logic               list_end,
    input  logic               last,

    output int                 failures,
    output int                 chunks_pending
);

    typedef struct packed {
        logic [14:0] tile_code;
        logic [7:0]  colour;
        logic        flip_x;
        logic        flip_y;
        logic [9:0]  pos_x;
        logic [9:0]  pos_y;
        logic [4:0]  size_x;
        logic [3:0]  size_y;
        logic        priority_res;
        logic        chunk_valid;
        logic        list_end;
        logic        last;
    } chunk_t;

    chunk_t      expected_chunks [$];
    logic [15:0] map_copy [0:32767];

    function automatic int signed_coord(input int v);
        return (v > int'(zsce_pkg::SIGN_LIMIT)) ? v - int'(zsce_pkg::COORD_WRAP) : v;
    endfunction

    // one row of a sprite: eight chunks, or the end-of-list marker
    task automatic expand_row(input logic [15:0] w0, input logic [15:0] w1,
                              input logic [15:0] w2, input logic [15:0] w3,
                              input logic [3:0] row);
        chunk_t      c;
        int          zx;
        int          zy;
        int          x;
        int          y;
        logic [3:0]  prow;
        logic [2:0]  pcol;
        logic [15:0] code;
        c = '0;
        if (w0[8:0] == zsce_pkg::END_OF_LIST_Y)
        begin
            c.list_end = 1'b1;
            c.last     = 1'b1;
            expected_chunks.push_back(c);
            return;
        end
        zx   = int'(w1[6:0]) + 1;
        zy   = int'(w0[15:9]) + 1;
        x    = signed_coord(int'(w2[8:0]));
        y    = signed_coord(int'(w0[8:0]) + int'(zsce_pkg::Y_BIAS) - zy);
        prow = w1[15] ? ~row : row;
        for (int k = 0; k < 8; k++)
        begin
            pcol           = w2[14] ? ~3'(k) : 3'(k);
            code           = map_copy[{w3[7:0], prow, pcol}];
            c.tile_code    = code[14:0];
            c.colour       = w3[15:8];
            c.flip_x       = w2[14];
            c.flip_y       = w1[15];
            c.pos_x        = 10'(x + (k * zx) / 8);
            c.pos_y        = 10'(y + (int'(row) * zy) / 16);
            c.size_x       = 5'(((k + 1) * zx) / 8 - (k * zx) / 8);
            c.size_y       = 4'(((int'(row) + 1) * zy) / 16 - (int'(row) * zy) / 16);
            c.priority_res = w2[15];
            c.chunk_valid  = ~code[15];
            c.list_end     = 1'b0;
            c.last         = (k == 7);
            expected_chunks.push_back(c);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin : watch
        chunk_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_chunks.size() == 0)
                begin
                    $error("chunk result with no request outstanding");
                    failures++;
                end
                else
                begin
                    want = expected_chunks.pop_front();
                    check_field("tile_code", want.tile_code, tile_code);
                    check_field("colour", want.colour, colour);
                    check_field("flip_x", want.flip_x, flip_x);
                    check_field("flip_y", want.flip_y, flip_y);
                    check_field("pos_x", $signed(want.pos_x), pos_x);
                    check_field("pos_y", $signed(want.pos_y), pos_y);
                    check_field("size_x", want.size_x, size_x);
                    check_field("size_y", want.size_y, size_y);
                    check_field("priority_res", want.priority_res, priority_res);
                    check_field("chunk_valid", want.chunk_valid, chunk_valid);
                    check_field("list_end", want.list_end, list_end);
                    check_field("last", want.last, last);
                end
            end
            if (in_valid && !in_stall)
            begin
                if (action == zsce_pkg::ACT_WRITE)
                    map_copy[map_address] = map_data;
                else
                    expand_row(desc_word0, desc_word1, desc_word2, desc_word3, row_index);
            end
            chunks_pending = expected_chunks.size();
        end
    end

endmodule

/* tb/tb_top.sv */
// tb_top: stimulus and verdict for zoomed_sprite_chunk_expander; checking is
// done by zsce_checker, types and constants come from zsce_pkg
`timescale 1ns / 1ps

module tb_top;

    logic               clk;
    logic               rst_n;

    logic               in_valid;
    logic               in_stall;
    logic               action;
    logic [14:0]        map_address;
    logic [15:0]        map_data;
    logic [15:0]        desc_word0;
    logic [15:0]        desc_word1;
    logic [15:0]        desc_word2;
    logic [15:0]        desc_word3;
    logic [3:0]         row_index;

    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [14:0]        tile_code;
    logic [7:0]         colour;
    logic               flip_x;
    logic               flip_y;
    logic signed [9:0]  pos_x;
    logic signed [9:0]  pos_y;
    logic [4:0]         size_x;
    logic [3:0]         size_y;
    logic               priority_res;
    logic               chunk_valid;
    logic               list_end;
    logic               last;

    int                 check_failures;
    int                 check_pending;
    // requests taken so far, directed ones included
    int                 items_sent;

    // map words the checker already holds; expands only ever read these
    bit                 map_written [0:32767];
    // set during the stretch where neither side idles
    bit                 no_idle;

    zoomed_sprite_chunk_expander u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .map_address  (map_address),
        .map_data     (map_data),
        .desc_word0   (desc_word0),
        .desc_word1   (desc_word1),
        .desc_word2   (desc_word2),
        .desc_word3   (desc_word3),
        .row_index    (row_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tile_code    (tile_code),
        .colour       (colour),
        .flip_x       (flip_x),
        .flip_y       (flip_y),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .size_x       (size_x),
        .size_y       (size_y),
        .priority_res (priority_res),
        .chunk_valid  (chunk_valid),
        .list_end     (list_end),
        .last         (last)
    );

    zsce_checker u_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .map_address    (map_address),
        .map_data       (map_data),
        .desc_word0     (desc_word0),
        .desc_word1     (desc_word1),
        .desc_word2     (desc_word2),
        .desc_word3     (desc_word3),
        .row_index      (row_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .tile_code      (tile_code),
        .colour         (colour),
        .flip_x         (flip_x),
        .flip_y         (flip_y),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .size_x         (size_x),
        .size_y         (size_y),
        .priority_res   (priority_res),
        .chunk_valid    (chunk_valid),
        .list_end       (list_end),
        .last           (last),
        .failures       (check_failures),
        .chunks_pending (check_pending)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard limit, far above the slowest legal run
    initial
    begin
        #5_000_000;
        $display("[zoomed_sprite_chunk_expander] ERROR");
        $finish;
    end

    // result side: stall with a chance of about 7 in 100 at each falling edge, never in the quiet stretch
    always @(negedge clk)
        out_stall = !no_idle && ($urandom_range(99) < 7);

    // present one request at the falling edge and hold it until taken
    task automatic push_request(input logic act, input logic [14:0] addr,
                                input logic [15:0] data,
                                input logic [15:0] w0, input logic [15:0] w1,
                                input logic [15:0] w2, input logic [15:0] w3,
                                input logic [3:0] row);
        // random idle gap ahead of the request
        while (!no_idle && $urandom_range(99) < 7)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        action      = act;
        map_address = addr;
        map_data    = data;
        desc_word0  = w0;
        desc_word1  = w1;
        desc_word2  = w2;
        desc_word3  = w3;
        row_index   = row;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
        items_sent++;
        if (act == zsce_pkg::ACT_WRITE)
            map_written[addr] = 1'b1;
    endtask

    // map write; descriptor lanes carry noise the block must ignore
    task automatic send_write(input logic [14:0] addr, input logic [15:0] data);
        push_request(zsce_pkg::ACT_WRITE, addr, data, 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 4'($urandom));
    endtask

    // row expand; any map word of the row not yet written is filled first
    task automatic send_expand(input logic [15:0] w0, input logic [15:0] w1,
                               input logic [15:0] w2, input logic [15:0] w3,
                               input logic [3:0] row);
        logic [3:0]  prow;
        logic [14:0] addr;
        if (w0[8:0] != zsce_pkg::END_OF_LIST_Y)
        begin
            // vertical flip picks the mirrored chunk row of the map
            prow = w1[15] ? ~row : row;
            for (int px = 0; px < 8; px++)
            begin
                addr = {w3[7:0], prow, 3'(px)};
                if (!map_written[addr])
                    send_write(addr, 16'($urandom));
            end
        end
        push_request(zsce_pkg::ACT_EXPAND, 15'($urandom), 16'($urandom),
                     w0, w1, w2, w3, row);
    endtask

    // hold the request side until every expected chunk has come back
    task automatic drain_results();
        in_valid = 1'b0;
        while (check_pending != 0)
            @(negedge clk);
    endtask

    // a few tiles that writes and expands keep returning to
    function automatic logic [7:0] hot_tile();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return 8'h7e;
            default: return 8'hff;
        endcase
    endfunction

    initial
    begin : stimulus
        logic [7:0]  tile;
        logic [14:0] addr;
        int          pick;
        bit          mid_drained;

        // every input known from time zero
        rst_n       = 1'b0;
        no_idle     = 1'b0;
        mid_drained = 1'b0;
        in_valid    = 1'b0;
        action      = zsce_pkg::ACT_WRITE;
        map_address = '0;
        map_data    = '0;
        desc_word0  = '0;
        desc_word1  = '0;
        desc_word2  = '0;
        desc_word3  = '0;
        row_index   = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ---- directed part ----
        // map extremes: top word all ones, bottom word all zeros
        send_write(15'h7fff, 16'hffff);
        send_write(15'h0000, 16'h0000);
        // invalid chunk: bit 15 set in one word of tile 1 row 2
        send_write({8'h01, 4'd2, 3'd3}, 16'h8000 | 16'($urandom_range(16'h7fff)));
        // smallest zoom, origin, no flips, row 0
        send_expand({7'h00, 9'h000}, 16'h0000, 16'h0000, 16'h0000, 4'd0);
        // largest zoom, both flips, priority, all-ones position, last row
        send_expand({7'h7f, 9'h1ff}, 16'h807f, 16'hffff, 16'hffff, 4'd15);
        // end of list with noise around the marker
        send_expand({7'h55, zsce_pkg::END_OF_LIST_Y}, 16'($urandom), 16'($urandom),
                    16'($urandom), 4'($urandom));
        send_expand({7'h00, zsce_pkg::END_OF_LIST_Y}, 16'h0000, 16'h0000, 16'h0000, 4'd0);
        // x right at the sign limit and one past it
        send_expand({7'h3f, 9'h010}, 16'h000f, 16'h0140, 16'h1234, 4'd7);
        send_expand({7'h3f, 9'h010}, 16'h000f, 16'h0141, 16'h1234, 4'd8);
        // y after bias right at the sign limit and one past it (full zoom)
        send_expand({7'h7f, 9'd317}, 16'h0040, 16'h0020, 16'h5601, 4'd2);
        send_expand({7'h7f, 9'd318}, 16'h0040, 16'h0020, 16'h5601, 4'd2);
        // invalid chunk read back under horizontal flip, ignored x bits set
        send_expand({7'h1a, 9'h0a0}, 16'h0033, 16'h7e55, 16'ha501, 4'd2);
        // same row reached through vertical flip from row 13
        send_expand({7'h05, 9'h0f0}, 16'h8011, 16'h0100, 16'h3c01, 4'd13);
        // let everything come back before the random part
        drain_results();

        // ---- random part ----
        // runs until about 160 requests have gone in
        while (items_sent < 160)
        begin
            // quiet stretch with no idling on either side
            no_idle = (items_sent >= 90 && items_sent < 130);
            pick    = $urandom_range(99);
            tile    = ($urandom_range(9) < 7) ? hot_tile() : 8'($urandom);
            if (pick < 30)
            begin
                // half of the writes land on the picked tile, mostly a hot one, so expands see them change
                addr = ($urandom_range(1) != 0) ? {tile, 7'($urandom)} : 15'($urandom);
                send_write(addr, 16'($urandom));
            end
            else if (pick < 38)
                send_expand({7'($urandom), zsce_pkg::END_OF_LIST_Y}, 16'($urandom),
                            16'($urandom), 16'($urandom), 4'($urandom));
            else
                send_expand(16'($urandom), 16'($urandom), 16'($urandom),
                            {8'($urandom), tile}, 4'($urandom));
            // one more full pause late in the run
            if (!mid_drained && items_sent >= 130)
            begin
                drain_results();
                mid_drained = 1'b1;
            end
        end

        // ---- wind down ----
        no_idle  = 1'b0;
        in_valid = 1'b0;
        for (int t = 0; t < 20000 && check_pending != 0; t++)
            @(negedge clk);
        if (check_pending != 0)
            $error("%0d chunk results never arrived", check_pending);
        // wait on to catch stray results
        repeat (40) @(negedge clk);
        if (check_failures == 0 && check_pending == 0)
            $display("[zoomed_sprite_chunk_expander] OK");
        else
            $display("[zoomed_sprite_chunk_expander] ERROR");
        $finish;
    end

endmodule
